FILE: hw/rtl/ufe_pkg.sv
// Shared types and constants for the union-find engine.
// No dependencies; imported by ufe_dp, ufe_ctrl and union_find_engine_top.
`default_nettype none

package ufe_pkg;

	localparam int SET_COUNT = 128;
	localparam int ELEM_W    = 8;
	localparam int IDX_W     = $clog2(SET_COUNT);
	localparam int ENTRY_W   = 9;

	// table entry: parent element (positive) or negated tree height
	typedef logic signed [ENTRY_W-1:0] entry_t;

	localparam entry_t HEIGHT_FLOOR = entry_t'(-255);

	typedef enum logic [1:0] {
		OP_FIND  = 2'd0,
		OP_UNION = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ELEM_W-1:0] first_element;
		logic [ELEM_W-1:0] second_element;
	} req_t;

	typedef struct packed {
		logic [ELEM_W-1:0] root;
		logic              error;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WALK_A,
		S_COMP_A,
		S_WALK_B,
		S_COMP_B,
		S_UNION,
		S_LINK,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		CUR_HOLD,
		CUR_A,
		CUR_B,
		CUR_ENTRY
	} cur_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CUR_TOP,
		WR_R1_R2,
		WR_R1_DEC,
		WR_R2_R1
	} wr_sel_t;

	typedef enum logic [2:0] {
		RES_HOLD,
		RES_TOP,
		RES_R1,
		RES_ZERO,
		RES_ERR
	} res_sel_t;

	typedef struct packed {
		logic     req_load;
		logic     clear;
		logic     top_load;
		logic     r1_load;
		logic     out_load;
		cur_sel_t cur_sel;
		wr_sel_t  wr_sel;
		res_sel_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       a_ok;
		logic       b_ok;
		logic       ab_same;
		logic       entry_pos;
		logic       cur_is_top;
		logic       same_root;
		logic       r2_deeper;
		logic       grow;
		logic       out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ufe_dp.sv
// Datapath: parent table memory with valid bits, walk registers, result and output register.
// Depends on ufe_pkg; driven by ufe_ctrl through dp_cmd_t.
`default_nettype none

module ufe_dp import ufe_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire req_t    req,
	input  wire logic    rsp_stall,
	output logic         rsp_valid,
	output rsp_t         rsp,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts
);

	function automatic logic [IDX_W-1:0] elem_idx(input logic [ELEM_W-1:0] e);
		logic [ELEM_W-1:0] m;
		m = e - ELEM_W'(1);
		return m[IDX_W-1:0];
	endfunction

	req_t              req_q;
	logic [ELEM_W-1:0] cur_q;
	logic [ELEM_W-1:0] top_q;
	logic [ELEM_W-1:0] r1_q;
	entry_t            htop_q;
	entry_t            h1_q;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	entry_t            mem [SET_COUNT];
	logic [SET_COUNT-1:0] vld_q;
	entry_t            rd_data_q;
	logic              rd_vld_q;

	entry_t            entry;
	logic [ELEM_W-1:0] cur_d;
	logic              wr_en;
	logic [ELEM_W-1:0] wr_elem;
	entry_t            wr_data;
	logic [IDX_W-1:0]  wr_idx;

	// entries never written since the last clear read as a root of height zero
	assign entry = rd_vld_q ? rd_data_q : '0;

	always_comb begin
		case (cmd.cur_sel)
			CUR_A:     cur_d = req_q.first_element;
			CUR_B:     cur_d = req_q.second_element;
			CUR_ENTRY: cur_d = entry[ELEM_W-1:0];
			default:   cur_d = cur_q;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_elem = cur_q;
		wr_data = $signed({1'b0, top_q});
		case (cmd.wr_sel)
			WR_CUR_TOP: begin
				wr_elem = cur_q;
				wr_data = $signed({1'b0, top_q});
			end
			WR_R1_R2: begin
				wr_elem = r1_q;
				wr_data = $signed({1'b0, top_q});
			end
			WR_R1_DEC: begin
				wr_elem = r1_q;
				wr_data = h1_q - entry_t'(1);
			end
			WR_R2_R1: begin
				wr_elem = top_q;
				wr_data = $signed({1'b0, r1_q});
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign wr_idx = elem_idx(wr_elem);

	// table: one write port, one registered read port following the walk pointer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rd_data_q <= mem[elem_idx(cur_d)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			rd_vld_q <= vld_q[elem_idx(cur_d)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_q <= req;
		end
		cur_q <= cur_d;
		if (cmd.top_load) begin
			top_q  <= cur_q;
			htop_q <= entry;
		end
		if (cmd.r1_load) begin
			r1_q <= top_q;
			h1_q <= htop_q;
		end
		case (cmd.res_sel)
			RES_TOP:  res_q <= '{root: top_q, error: 1'b0};
			RES_R1:   res_q <= '{root: r1_q, error: 1'b0};
			RES_ZERO: res_q <= '{root: '0, error: 1'b0};
			RES_ERR:  res_q <= '{root: '0, error: 1'b1};
			default:  res_q <= res_q;
		endcase
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		sts.op         = req_q.opcode;
		sts.a_ok       = (req_q.first_element != '0) &&
		                 (req_q.first_element <= ELEM_W'(SET_COUNT));
		sts.b_ok       = (req_q.second_element != '0) &&
		                 (req_q.second_element <= ELEM_W'(SET_COUNT));
		sts.ab_same    = req_q.first_element == req_q.second_element;
		sts.entry_pos  = entry > entry_t'(0);
		sts.cur_is_top = cur_q == top_q;
		sts.same_root  = r1_q == top_q;
		sts.r2_deeper  = htop_q < h1_q;
		sts.grow       = (htop_q == h1_q) && (h1_q > HEIGHT_FLOOR);
		sts.out_free   = !rsp_valid_q || !rsp_stall;
	end

	a_no_wr_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear && wr_en))
		else $error("table write coincides with clear");

	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(wr_idx)])
		else $error("written entry not marked valid");

	a_no_self_parent: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_data > entry_t'(0)) |-> (wr_data[ELEM_W-1:0] != wr_elem))
		else $error("entry linked to itself");

	a_err_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && res_q.error) |-> (res_q.root == '0))
		else $error("error result carries a root");

endmodule

`default_nettype wire

FILE: hw/rtl/ufe_ctrl.sv
// Controller: sequences find walks, path compression and union linking.
// Depends on ufe_pkg; commands ufe_dp, reads its status.
`default_nettype none

module ufe_ctrl import ufe_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.cur_sel  = CUR_HOLD;
		cmd.wr_sel   = WR_NONE;
		cmd.res_sel  = RES_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_FIND: begin
						if (sts.a_ok) begin
							cmd.cur_sel = CUR_A;
							state_d     = S_WALK_A;
						end else begin
							cmd.res_sel = RES_ERR;
							state_d     = S_FINISH;
						end
					end
					OP_UNION: begin
						if (sts.a_ok && sts.b_ok && !sts.ab_same) begin
							cmd.cur_sel = CUR_A;
							state_d     = S_WALK_A;
						end else begin
							cmd.res_sel = RES_ERR;
							state_d     = S_FINISH;
						end
					end
					OP_CLEAR: begin
						cmd.clear   = 1'b1;
						cmd.res_sel = RES_ZERO;
						state_d     = S_FINISH;
					end
					default: begin
						cmd.res_sel = RES_ZERO;
						state_d     = S_FINISH;
					end
				endcase
			end
			S_WALK_A, S_WALK_B: begin
				if (sts.entry_pos) begin
					cmd.cur_sel = CUR_ENTRY;
				end else begin
					cmd.top_load = 1'b1;
					cmd.cur_sel  = (state_q == S_WALK_A) ? CUR_A : CUR_B;
					state_d      = (state_q == S_WALK_A) ? S_COMP_A : S_COMP_B;
				end
			end
			S_COMP_A: begin
				if (sts.entry_pos && !sts.cur_is_top) begin
					cmd.wr_sel  = WR_CUR_TOP;
					cmd.cur_sel = CUR_ENTRY;
				end else if (sts.op == OP_UNION) begin
					cmd.r1_load = 1'b1;
					cmd.cur_sel = CUR_B;
					state_d     = S_WALK_B;
				end else begin
					cmd.res_sel = RES_TOP;
					state_d     = S_FINISH;
				end
			end
			S_COMP_B: begin
				if (sts.entry_pos && !sts.cur_is_top) begin
					cmd.wr_sel  = WR_CUR_TOP;
					cmd.cur_sel = CUR_ENTRY;
				end else begin
					state_d = S_UNION;
				end
			end
			S_UNION: begin
				if (sts.same_root) begin
					cmd.res_sel = RES_R1;
					state_d     = S_FINISH;
				end else if (sts.r2_deeper) begin
					cmd.wr_sel  = WR_R1_R2;
					cmd.res_sel = RES_TOP;
					state_d     = S_FINISH;
				end else if (sts.grow) begin
					cmd.wr_sel = WR_R1_DEC;
					state_d    = S_LINK;
				end else begin
					cmd.wr_sel  = WR_R2_R1;
					cmd.res_sel = RES_R1;
					state_d     = S_FINISH;
				end
			end
			S_LINK: begin
				cmd.wr_sel  = WR_R2_R1;
				cmd.res_sel = RES_R1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.req_load |=> (state_q == S_DECODE))
		else $error("request taken outside idle");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (state_q == S_FINISH) && sts.out_free)
		else $error("response loaded while output busy");

	a_clear_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (state_q == S_FINISH))
		else $error("clear did not complete directly");

endmodule

`default_nettype wire

FILE: hw/rtl/union_find_engine_top.sv
// Top level of the union-find engine: disjoint-set table, union by height, path compression.
// Depends on ufe_pkg, ufe_ctrl and ufe_dp.
`default_nettype none

//  Channel  | Handshake             | Payload | Direction
//  ---------+-----------------------+---------+----------
//  request  | req_valid / req_stall | req_t   | in
//  response | rsp_valid / rsp_stall | rsp_t   | out
//
// One request at a time. Find walks from the element up to its root and
// back to compress the path; union does so for both elements and links the
// roots, in a separate link step when equal heights need it; clear, invalid
// and unused requests go straight to the finish step. The pointer walk over
// the single-read table memory goes one parent per cycle up, one per cycle
// back. Reset and clear drop every per-entry valid bit at once, so there is
// no clearing pass. A stalled response waits in the output register while
// the next request is taken and worked on; it only holds the finish step.

module union_find_engine_top import ufe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// command and status between sequencer and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller: request handshake and operation sequencing
	ufe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: parent table, walk pointers and response register
	ufe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

FILE: sim/tb_union_find_engine_top.sv
// Self-checking testbench for union_find_engine_top: a queue-fed driver, a monitor and a
// cycle-free disjoint-set predictor that tracks the table through every accepted request.
// Depends on ufe_pkg and the union-find engine RTL.
`timescale 1ns / 100ps

module tb_union_find_engine_top;
	import ufe_pkg::*;

	typedef struct {
		req_t body;
		bit   hold;	// wait for every due response before issuing
	} req_entry_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	req_entry_t req_backlog[$];
	rsp_t       rsp_due[$];
	entry_t     forest[1:SET_COUNT];
	int         issue_gap;
	int         stall_left;
	int         issued;
	int         seen;
	int         errors;

	union_find_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// root of e, pointing every node on the walked path straight at it
	function automatic int find_root(input int e);
		int top;
		int nxt;
		int steps;
		top = e;
		steps = 0;
		while (forest[top] > 0 && steps < SET_COUNT) begin
			nxt = forest[top];
			if (nxt < 1 || nxt > SET_COUNT)
				break;
			top = nxt;
			steps++;
		end
		steps = 0;
		while (e != top && forest[e] > 0 && steps < SET_COUNT) begin
			nxt = forest[e];
			forest[e] = entry_t'(top);
			if (nxt < 1 || nxt > SET_COUNT)
				break;
			e = nxt;
			steps++;
		end
		return top;
	endfunction

	function automatic rsp_t apply_request(input req_t q);
		rsp_t o;
		int   a;
		int   b;
		int   r1;
		int   r2;
		bit   a_ok;
		bit   b_ok;
		o = '0;
		a = q.first_element;
		b = q.second_element;
		a_ok = (a >= 1 && a <= SET_COUNT);
		b_ok = (b >= 1 && b <= SET_COUNT);
		case (op_t'(q.opcode))
			OP_FIND: begin
				if (a_ok)
					o.root = ELEM_W'(find_root(a));
				else
					o.error = 1'b1;
			end
			OP_UNION: begin
				if (!a_ok || !b_ok || a == b) begin
					o.error = 1'b1;
				end else begin
					r1 = find_root(a);
					r2 = find_root(b);
					if (r1 == r2) begin
						o.root = ELEM_W'(r1);
					end else if (forest[r2] < forest[r1]) begin
						forest[r1] = entry_t'(r2);
						o.root = ELEM_W'(r2);
					end else begin
						// equal heights: first root wins and grows
						if (forest[r1] == forest[r2] && forest[r1] > HEIGHT_FLOOR)
							forest[r1] = forest[r1] - entry_t'(1);
						forest[r2] = entry_t'(r1);
						o.root = ELEM_W'(r1);
					end
				end
			end
			OP_CLEAR: begin
				foreach (forest[i])
					forest[i] = '0;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic push_req(input op_t op, input int a, input int b, input bit hold);
		req_entry_t ent;
		ent.body.opcode         = op;
		ent.body.first_element  = ELEM_W'(a);
		ent.body.second_element = ELEM_W'(b);
		ent.hold                = hold;
		req_backlog.push_back(ent);
	endtask

	function automatic int bad_element();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(SET_COUNT + 1, 255);
	endfunction

	// driver: predicts at acceptance, so due responses stay in request order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			issue_gap = 0;
			issued    = 0;
			rsp_due.delete();
			foreach (forest[i])
				forest[i] = '0;
		end else begin
			if (req_valid && !req_stall) begin
				rsp_due.push_back(apply_request(req));
				issued++;
			end
			if (!(req_valid && req_stall)) begin
				if (issue_gap > 0) begin
					issue_gap--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() > 0 &&
						!(req_backlog[0].hold && rsp_due.size() > 0)) begin
					req_valid <= 1'b1;
					req       <= req_backlog[0].body;
					void'(req_backlog.pop_front());
					issue_gap = pick_gap(((issued / 150) % 4) == 3);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, field-by-field check against the oldest due response
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
			seen       = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				seen++;
				if (rsp_due.size() == 0) begin
					$display("%0t: unexpected response root=%0d error=%0b",
						$time, rsp.root, rsp.error);
					errors++;
				end else begin
					if (rsp.root !== rsp_due[0].root) begin
						$display("%0t: root mismatch, expected %0d got %0d",
							$time, rsp_due[0].root, rsp.root);
						errors++;
					end
					if (rsp.error !== rsp_due[0].error) begin
						$display("%0t: error mismatch, expected %0b got %0b",
							$time, rsp_due[0].error, rsp.error);
						errors++;
					end
					void'(rsp_due.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				if (((seen / 150) % 4) == 1)
					stall_left = 0;
				else
					stall_left = pick_gap(1'b0) + ($urandom_range(0, 9) == 0 ? 10 : 0);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("union_find_engine_top verification failed");
		$finish;
	end

	initial begin
		int r;
		int a;
		int b;
		errors = 0;
		arst_n = 1'b0;

		// extremes, out-of-range elements, union of an element with itself
		push_req(OP_FIND, 1, 255, 0);
		push_req(OP_FIND, SET_COUNT, 0, 0);
		push_req(OP_FIND, 0, 0, 0);
		push_req(OP_FIND, 255, 255, 0);
		push_req(OP_FIND, SET_COUNT + 1, 1, 0);
		push_req(OP_UNION, 5, 5, 0);
		push_req(OP_UNION, 0, 3, 0);
		push_req(OP_UNION, 3, 200, 0);
		// build trees: equal heights, deeper wins, non-root arguments, same set; then unused opcode and clear
		push_req(OP_UNION, 1, 2, 0);
		push_req(OP_UNION, 3, 4, 0);
		push_req(OP_UNION, 1, 3, 0);
		push_req(OP_UNION, SET_COUNT, SET_COUNT - 1, 0);
		push_req(OP_UNION, SET_COUNT, 1, 0);
		push_req(OP_UNION, 4, SET_COUNT - 1, 0);
		push_req(OP_FIND, 4, 170, 0);
		push_req(OP_UNION, 6, 2, 0);
		push_req(OP_NOP, 255, 255, 0);
		push_req(OP_NOP, 0, 0, 0);
		push_req(OP_CLEAR, 170, 85, 0);
		push_req(OP_FIND, 4, 85, 1);
		push_req(OP_UNION, 2, 1, 0);
		push_req(OP_UNION, 255, 255, 0);
		push_req(OP_FIND, 2, 0, 0);

		// mostly unions and finds on valid elements, so trees get tall before a rare clear
		for (int n = 0; n < 1030; n++) begin
			r = $urandom_range(0, 999);
			a = $urandom_range(1, SET_COUNT);
			b = $urandom_range(1, SET_COUNT);
			if (b == a)
				b = (a % SET_COUNT) + 1;
			if (r < 450)
				push_req(OP_UNION, a, b, n == 500);
			else if (r < 840)
				push_req(OP_FIND, a, $urandom_range(0, 255), n == 500);
			else if (r < 848)
				push_req(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), 0);
			else if (r < 880)
				push_req(OP_FIND, bad_element(), $urandom_range(0, 255), 0);
			else if (r < 910)
				push_req(OP_UNION, ($urandom_range(0, 1) ? bad_element() : a),
					bad_element(), 0);
			else if (r < 940)
				push_req(OP_UNION, a, a, 0);
			else if (r < 970)
				push_req(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 255), 0);
			else
				push_req(OP_UNION, $urandom_range(1, 8), $urandom_range(9, SET_COUNT),
					$urandom_range(0, 7) == 0);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() > 0 || req_valid)
			@(posedge clk);
		while (rsp_due.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (errors == 0)
			$display("union_find_engine_top verification clean");
		else
			$display("union_find_engine_top verification failed");
		$finish;
	end

endmodule
